// ===== rtl/ecss_pkg.sv =====
// Package: codes, result type and helpers for the exception stack frame sequencer.
`timescale 1ns / 1ps

package ecss_pkg;

  localparam int unsigned InTdataW  = 80;
  localparam int unsigned OutTdataW = 144;

  // operation codes
  localparam logic [1:0] OP_ENTRY  = 2'd0;
  localparam logic [1:0] OP_RETURN = 2'd1;
  localparam logic [1:0] OP_WORD   = 2'd2;

  // access codes of a result item
  localparam logic [2:0] ACC_WRITE  = 3'd1;
  localparam logic [2:0] ACC_READ   = 3'd2;
  localparam logic [2:0] ACC_DONE   = 3'd3;
  localparam logic [2:0] ACC_ERROR  = 3'd4;

  // configuration register indexes
  localparam logic CFG_VECTOR_BASE = 1'b0;
  localparam logic CFG_THREAD_UNPRIV = 1'b1;

  // return code low nibble values
  localparam logic [3:0] RET_HANDLER    = 4'd1;
  localparam logic [3:0] RET_THREAD_MSP = 4'd9;
  localparam logic [3:0] RET_THREAD_PSP = 4'd13;

  localparam logic [31:0] LR_HANDLER    = 32'hFFFF_FFF1;
  localparam logic [31:0] LR_THREAD_MSP = 32'hFFFF_FFF9;
  localparam logic [31:0] LR_THREAD_PSP = 32'hFFFF_FFFD;

  localparam logic [31:0] FRAME_SIZE = 32'h0000_0020;
  localparam logic [2:0]  LAST_WORD  = 3'd7;
  localparam logic [2:0]  PC_WORD    = 3'd6;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PUSH,
    PH_POP
  } phase_t;

  typedef struct packed {
    logic [2:0]  acc;
    logic [31:0] address;
    logic [31:0] data;
    logic [31:0] link;
    logic [31:0] nsp;
    logic        thread;
    logic        spsel;
    logic [5:0]  ipsr;
    logic [3:0]  flags;
    logic [2:0]  epsr;
    logic        last;
  } result_t;

  function automatic logic exception_known(input logic [5:0] n);
    exception_known = (n == 6'd2) || (n == 6'd3) || (n == 6'd11) || (n == 6'd14) ||
                      (n == 6'd15) || (n >= 6'd16);
  endfunction

endpackage

// ===== rtl/exception_stack_frame_sequencer_core.sv =====
// Top level: ARMv6-M exception entry and return stack frame sequencer.
`timescale 1ns / 1ps

// Takes one item per cycle. An entry, a return or a frame word is decoded and the
// stacking state updated in the cycle it is accepted; the result items it causes are
// held in a burst register and then leave through the output register, one per cycle.
// Most items cause zero or one result, so items stream at one per cycle. A return
// causes eight bus reads and the eighth pushed word a write plus the vector fetch;
// the input stalls until the last item of such a burst moves to the output register.
// Output back-pressure stalls the input only once the burst register is occupied.
module exception_stack_frame_sequencer_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // exception_number, return_code, stack_pointer, word, zero pad
  input  logic [ecss_pkg::InTdataW-1:0]     s_tdata,
  // operation
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // address, data, link_value, new_stack_pointer, in_thread_mode,
  // process_stack_selected, interrupt_status, condition_flags, execution_status, zero pad
  output logic [ecss_pkg::OutTdataW-1:0]    m_tdata,
  // access
  output logic [2:0]                        m_tuser,
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [31:0]                       cfg_data
);
  import ecss_pkg::*;

  // configuration
  logic [31:0] vector_base;
  logic        thread_unprivileged;

  // stacking state
  logic [31:0] main_sp, main_sp_next;
  logic [31:0] process_sp, process_sp_next;
  logic        thread_mode, thread_mode_next;
  logic        spsel_bit, spsel_bit_next;
  logic [5:0]  current_ipsr, current_ipsr_next;
  logic [31:0] frame_base, frame_base_next;
  logic        frame_align, frame_align_next;
  logic [2:0]  word_index, word_index_next;
  phase_t      phase, phase_next;
  logic [5:0]  pending_exception, pending_exception_next;
  logic [3:0]  pending_code, pending_code_next;
  logic [31:0] popped_pc, popped_pc_next;

  // burst register
  logic        bvalid;
  logic [2:0]  bidx;
  logic [2:0]  bend;
  logic        bstep;
  result_t     r0;
  result_t     r1;

  // output register
  logic        ovalid;
  result_t     oitem;

  // input fields
  logic [1:0]  in_op;
  logic [5:0]  in_exc;
  logic [3:0]  in_code;
  logic [31:0] in_sp;
  logic [31:0] in_word;

  logic        in_fire;
  logic        emit;
  logic        load;
  logic [2:0]  ld_end;
  logic        ld_step;
  result_t     ld_r0;
  result_t     ld_r1;
  result_t     cur_res;
  result_t     sel;
  logic [31:0] cur_sp;
  logic [31:0] wr_addr;
  logic [31:0] new_base;
  logic [31:0] new_sp;
  logic [31:0] push_data;
  logic        ret_ok;

  assign in_op   = s_tuser;
  assign in_exc  = s_tdata[5:0];
  assign in_code = s_tdata[9:6];
  assign in_sp   = s_tdata[41:10];
  assign in_word = s_tdata[73:42];

  assign emit     = bvalid && (!ovalid || m_tready);
  assign s_tready = !bvalid || (emit && (bidx == bend));
  assign in_fire  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    main_sp_next           = main_sp;
    process_sp_next        = process_sp;
    thread_mode_next       = thread_mode;
    spsel_bit_next         = spsel_bit;
    current_ipsr_next      = current_ipsr;
    frame_base_next        = frame_base;
    frame_align_next       = frame_align;
    word_index_next        = word_index;
    phase_next             = phase;
    pending_exception_next = pending_exception;
    pending_code_next      = pending_code;
    popped_pc_next         = popped_pc;

    cur_sp = (thread_mode && spsel_bit) ? process_sp : main_sp;
    cur_res.acc     = ACC_ERROR;
    cur_res.address = '0;
    cur_res.data    = '0;
    cur_res.link    = '0;
    cur_res.nsp     = cur_sp;
    cur_res.thread  = thread_mode;
    cur_res.spsel   = spsel_bit;
    cur_res.ipsr    = current_ipsr;
    cur_res.flags   = '0;
    cur_res.epsr    = '0;
    cur_res.last    = 1'b1;

    wr_addr   = frame_base + {27'd0, word_index, 2'b00};
    new_base  = (in_sp - FRAME_SIZE) & ~32'h0000_0004;
    new_sp    = (frame_base + FRAME_SIZE) | {29'd0, in_word[9], 2'b00};
    push_data = in_word;
    if (word_index == LAST_WORD) begin
      push_data[9] = frame_align;
    end
    ret_ok = !thread_mode && ((in_code == RET_HANDLER) || (in_code == RET_THREAD_MSP) ||
                              (in_code == RET_THREAD_PSP));

    load    = 1'b0;
    ld_end  = '0;
    ld_step = 1'b0;
    ld_r0   = cur_res;
    ld_r1   = cur_res;

    if (in_fire) begin
      if (in_op == OP_ENTRY) begin
        if (phase == PH_IDLE) begin
          if (!exception_known(in_exc)) begin
            load = 1'b1;
          end else begin
            frame_align_next = in_sp[2];
            frame_base_next  = new_base;
            if (thread_mode && spsel_bit) begin
              process_sp_next = new_base;
            end else begin
              main_sp_next = new_base;
            end
            pending_exception_next = in_exc;
            word_index_next        = '0;
            phase_next             = PH_PUSH;
          end
        end
      end else if (in_op == OP_RETURN) begin
        if (phase == PH_IDLE) begin
          load = 1'b1;
          if (ret_ok) begin
            pending_code_next = in_code;
            frame_base_next   = (in_code == RET_THREAD_PSP) ? process_sp : main_sp;
            word_index_next   = '0;
            phase_next        = PH_POP;
            ld_end            = LAST_WORD;
            ld_step           = 1'b1;
            ld_r0.acc         = ACC_READ;
            ld_r0.address     = (in_code == RET_THREAD_PSP) ? process_sp : main_sp;
            ld_r0.last        = 1'b0;
            ld_r1             = ld_r0;
          end
        end
      end else if (in_op == OP_WORD) begin
        unique case (phase)
          PH_PUSH: begin
            load          = 1'b1;
            ld_r0.acc     = ACC_WRITE;
            ld_r0.address = wr_addr;
            ld_r0.data    = push_data;
            ld_r0.last    = 1'b0;
            if (word_index != LAST_WORD) begin
              word_index_next = word_index + 3'd1;
            end else begin
              thread_mode_next  = 1'b0;
              spsel_bit_next    = 1'b0;
              current_ipsr_next = pending_exception;
              word_index_next   = '0;
              phase_next        = PH_IDLE;
              ld_end            = 3'd1;
              ld_r1.acc         = ACC_READ;
              ld_r1.address     = vector_base + {24'd0, pending_exception, 2'b00};
              ld_r1.link        = !thread_mode ? LR_HANDLER :
                                  (!spsel_bit ? LR_THREAD_MSP : LR_THREAD_PSP);
              ld_r1.nsp         = main_sp;
              ld_r1.thread      = 1'b0;
              ld_r1.spsel       = 1'b0;
              ld_r1.ipsr        = pending_exception;
            end
          end
          PH_POP: begin
            if (word_index == PC_WORD) begin
              popped_pc_next = in_word;
            end
            if (word_index != LAST_WORD) begin
              word_index_next = word_index + 3'd1;
            end else begin
              load = 1'b1;
              if (pending_code == RET_THREAD_PSP) begin
                process_sp_next = new_sp;
                thread_mode_next = 1'b1;
                spsel_bit_next   = 1'b1;
              end else begin
                main_sp_next     = new_sp;
                thread_mode_next = (pending_code == RET_THREAD_MSP);
                spsel_bit_next   = 1'b0;
              end
              current_ipsr_next = ((pending_code != RET_HANDLER) && thread_unprivileged) ?
                                  6'd0 : in_word[5:0];
              word_index_next = '0;
              phase_next      = PH_IDLE;
              ld_r0.acc       = ACC_DONE;
              ld_r0.data      = popped_pc;
              ld_r0.nsp       = new_sp;
              ld_r0.thread    = thread_mode_next;
              ld_r0.spsel     = spsel_bit_next;
              ld_r0.ipsr      = current_ipsr_next;
              ld_r0.flags     = in_word[31:28];
              ld_r0.epsr      = in_word[26:24];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    sel = (bidx == 3'd0) ? r0 : r1;
    if (bstep) begin
      sel.address = sel.address + {27'd0, bidx, 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_base         <= '0;
      thread_unprivileged <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_VECTOR_BASE:   vector_base <= cfg_data;
        CFG_THREAD_UNPRIV: thread_unprivileged <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_sp           <= '0;
      process_sp        <= '0;
      thread_mode       <= 1'b1;
      spsel_bit         <= 1'b0;
      current_ipsr      <= '0;
      frame_base        <= '0;
      frame_align       <= 1'b0;
      word_index        <= '0;
      phase             <= PH_IDLE;
      pending_exception <= '0;
      pending_code      <= '0;
      popped_pc         <= '0;
    end else begin
      main_sp           <= main_sp_next;
      process_sp        <= process_sp_next;
      thread_mode       <= thread_mode_next;
      spsel_bit         <= spsel_bit_next;
      current_ipsr      <= current_ipsr_next;
      frame_base        <= frame_base_next;
      frame_align       <= frame_align_next;
      word_index        <= word_index_next;
      phase             <= phase_next;
      pending_exception <= pending_exception_next;
      pending_code      <= pending_code_next;
      popped_pc         <= popped_pc_next;
    end
  end

  // burst register: a new burst loads as the old one hands off its last item
  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= 1'b0;
      bidx   <= '0;
      bend   <= '0;
      bstep  <= 1'b0;
    end else if (load) begin
      bvalid <= 1'b1;
      bidx   <= '0;
      bend   <= ld_end;
      bstep  <= ld_step;
    end else if (emit) begin
      if (bidx == bend) begin
        bvalid <= 1'b0;
      end else begin
        bidx <= bidx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      r0 <= ld_r0;
      r1 <= ld_r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (emit) begin
      ovalid <= 1'b1;
    end else if (m_tready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oitem <= sel;
    end
  end

  assign m_tvalid = ovalid;
  assign m_tuser  = oitem.acc;
  assign m_tlast  = oitem.last;
  assign m_tdata  = {1'b0, oitem.epsr, oitem.flags, oitem.ipsr, oitem.spsel, oitem.thread,
                     oitem.nsp, oitem.link, oitem.data, oitem.address};

endmodule

// ===== verif/exception_stack_frame_sequencer_checker.sv =====
// Checker: predicts and compares the result items of the exception stack frame sequencer.
`timescale 1ns / 1ps

module exception_stack_frame_sequencer_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // exception_number, return_code, stack_pointer, word, zero pad
  input  logic [ecss_pkg::InTdataW-1:0]   s_tdata,
  // operation
  input  logic [1:0]                      s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // address, data, link_value, new_stack_pointer, in_thread_mode,
  // process_stack_selected, interrupt_status, condition_flags, execution_status, zero pad
  input  logic [ecss_pkg::OutTdataW-1:0]  m_tdata,
  // access
  input  logic [2:0]                      m_tuser,
  input  logic                            m_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [31:0]                     cfg_data,
  output int unsigned                     fail_count,
  output int unsigned                     results_due
);
  import ecss_pkg::*;

  logic [31:0] vec_base;
  logic        unpriv;
  logic [31:0] msp;
  logic [31:0] psp;
  logic [31:0] fbase;
  logic [31:0] ret_pc;
  logic        thr;
  logic        spsel;
  logic        falign;
  logic [5:0]  ipsr;
  logic [5:0]  pend_exc;
  logic [3:0]  pend_code;
  logic [2:0]  widx;
  phase_t      seq_phase;
  result_t     bus_ops_due[$];
  result_t     want;

  function automatic logic [31:0] active_sp();
    return (thr && spsel) ? psp : msp;
  endfunction

  task automatic queue_result(input logic [2:0] acc, input logic [31:0] addr,
                              input logic [31:0] data, input logic [31:0] link,
                              input logic [3:0] flags, input logic [2:0] epsr,
                              input logic last);
    result_t r;
    r.acc = acc;
    r.address = addr;
    r.data = data;
    r.link = link;
    r.nsp = active_sp();
    r.thread = thr;
    r.spsel = spsel;
    r.ipsr = ipsr;
    r.flags = flags;
    r.epsr = epsr;
    r.last = last;
    bus_ops_due.push_back(r);
  endtask

  task automatic step_stacking(input logic [1:0] op, input logic [5:0] exc,
                               input logic [3:0] code, input logic [31:0] sp,
                               input logic [31:0] w);
    logic [31:0] data;
    logic [31:0] link;
    logic [31:0] ofs;
    logic [31:0] nsp;
    if (op == OP_ENTRY && seq_phase == PH_IDLE) begin
      if (!(exc inside {6'd2, 6'd3, 6'd11, 6'd14, 6'd15} || exc >= 6'd16)) begin
        queue_result(ACC_ERROR, '0, '0, '0, '0, '0, 1'b1);
      end else begin
        falign = sp[2];
        fbase = (sp - FRAME_SIZE) & ~32'h4;
        if (thr && spsel) psp = fbase;
        else msp = fbase;
        pend_exc = exc;
        widx = '0;
        seq_phase = PH_PUSH;
      end
    end else if (op == OP_RETURN && seq_phase == PH_IDLE) begin
      if (thr || !(code inside {RET_HANDLER, RET_THREAD_MSP, RET_THREAD_PSP})) begin
        queue_result(ACC_ERROR, '0, '0, '0, '0, '0, 1'b1);
      end else begin
        pend_code = code;
        fbase = (code == RET_THREAD_PSP) ? psp : msp;
        widx = '0;
        seq_phase = PH_POP;
        ofs = '0;
        repeat (8) begin
          queue_result(ACC_READ, fbase + ofs, '0, '0, '0, '0, 1'b0);
          ofs = ofs + 32'd4;
        end
      end
    end else if (op == OP_WORD && seq_phase == PH_PUSH) begin
      data = w;
      if (widx == LAST_WORD) data[9] = falign;
      queue_result(ACC_WRITE, fbase + {27'd0, widx, 2'b00}, data, '0, '0, '0, 1'b0);
      if (widx != LAST_WORD) begin
        widx = widx + 3'd1;
      end else begin
        link = !thr ? LR_HANDLER : (!spsel ? LR_THREAD_MSP : LR_THREAD_PSP);
        thr = 1'b0;
        spsel = 1'b0;
        ipsr = pend_exc;
        widx = '0;
        seq_phase = PH_IDLE;
        queue_result(ACC_READ, vec_base + {24'd0, ipsr, 2'b00}, '0, link, '0, '0, 1'b1);
      end
    end else if (op == OP_WORD && seq_phase == PH_POP) begin
      if (widx == PC_WORD) ret_pc = w;
      if (widx != LAST_WORD) begin
        widx = widx + 3'd1;
      end else begin
        // popped xPSR bit 9 restores the alignment padding
        nsp = (fbase + FRAME_SIZE) | {29'd0, w[9], 2'b00};
        if (pend_code == RET_THREAD_PSP) begin
          psp = nsp;
          thr = 1'b1;
          spsel = 1'b1;
        end else begin
          msp = nsp;
          thr = (pend_code == RET_THREAD_MSP);
          spsel = 1'b0;
        end
        ipsr = (thr && unpriv) ? 6'd0 : w[5:0];
        widx = '0;
        seq_phase = PH_IDLE;
        queue_result(ACC_DONE, '0, ret_pc, '0, w[31:28], w[26:24], 1'b1);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] expv);
    $display("%0t mismatch %s: got %h, expected %h", $time, what, got, expv);
    fail_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] expv);
    if (got !== expv) report_mismatch(what, got, expv);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      vec_base = '0;
      unpriv = 1'b0;
      msp = '0;
      psp = '0;
      thr = 1'b1;
      spsel = 1'b0;
      ipsr = '0;
      fbase = '0;
      falign = 1'b0;
      widx = '0;
      seq_phase = PH_IDLE;
      pend_exc = '0;
      pend_code = '0;
      ret_pc = '0;
      bus_ops_due.delete();
      fail_count = 0;
      results_due = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (bus_ops_due.size() == 0) begin
          report_mismatch("unexpected item, access", {29'd0, m_tuser}, '0);
        end else begin
          want = bus_ops_due.pop_front();
          check_field("access", {29'd0, m_tuser}, {29'd0, want.acc});
          check_field("address", m_tdata[31:0], want.address);
          check_field("data", m_tdata[63:32], want.data);
          check_field("link_value", m_tdata[95:64], want.link);
          check_field("new_stack_pointer", m_tdata[127:96], want.nsp);
          check_field("in_thread_mode", {31'd0, m_tdata[128]}, {31'd0, want.thread});
          check_field("process_stack_selected", {31'd0, m_tdata[129]},
                      {31'd0, want.spsel});
          check_field("interrupt_status", {26'd0, m_tdata[135:130]}, {26'd0, want.ipsr});
          check_field("condition_flags", {28'd0, m_tdata[139:136]}, {28'd0, want.flags});
          check_field("execution_status", {29'd0, m_tdata[142:140]}, {29'd0, want.epsr});
          check_field("last", {31'd0, m_tlast}, {31'd0, want.last});
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_VECTOR_BASE) vec_base = cfg_data;
        else unpriv = cfg_data[0];
      end
      if (s_tvalid && s_tready)
        step_stacking(s_tuser, s_tdata[5:0], s_tdata[9:6], s_tdata[41:10], s_tdata[73:42]);
      results_due = bus_ops_due.size();
    end
  end

endmodule

// ===== verif/exception_stack_frame_sequencer_core_test.sv =====
// Testbench top: stimulus, idling and verdict for the exception stack frame sequencer.
`timescale 1ns / 1ps

module exception_stack_frame_sequencer_core_test;
  import ecss_pkg::*;

  localparam logic [1:0]  OP_UNUSED       = 2'd3;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned ITEMS_PER_PHASE = 50;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [InTdataW-1:0]  s_tdata;
  logic [1:0]           s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OutTdataW-1:0] m_tdata;
  logic [2:0]           m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_index;
  logic [31:0]          cfg_data;
  int unsigned          fail_count;
  int unsigned          results_due;
  int unsigned          tx_idle_pct;
  int unsigned          rx_idle_pct;
  int unsigned          cycles;
  int unsigned          items_sent;
  int unsigned          target;
  logic                 handler;

  exception_stack_frame_sequencer_core DUT (.*);

  exception_stack_frame_sequencer_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [5:0] exc, input logic [3:0] code,
                           input logic [31:0] sp, input logic [31:0] w, input bit counted);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tuser = op;
    s_tdata = {6'd0, w, sp, code, exc};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    if (counted) items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // entries or returns slipped into a running sequence are ignored by the block
  task automatic stray_item(input int unsigned noise_pct);
    if ($urandom_range(99) < noise_pct)
      send_item($urandom_range(1) ? OP_ENTRY : OP_RETURN, 6'($urandom), 4'($urandom),
                $urandom, $urandom, 1'b0);
  endtask

  task automatic entry_sequence(input logic [5:0] exc, input logic [31:0] sp,
                                input logic [31:0] xpsr, input int unsigned noise_pct);
    send_item(OP_ENTRY, exc, 4'($urandom), sp, $urandom, 1'b1);
    for (int k = 0; k < 8; k++) begin
      stray_item(noise_pct);
      send_item(OP_WORD, 6'($urandom), 4'($urandom), $urandom,
                (k == 7) ? xpsr : $urandom, 1'b1);
    end
    handler = 1'b1;
  endtask

  task automatic return_sequence(input logic [3:0] code, input logic [31:0] xpsr,
                                 input int unsigned noise_pct);
    send_item(OP_RETURN, 6'($urandom), code, $urandom, $urandom, 1'b1);
    for (int k = 0; k < 8; k++) begin
      stray_item(noise_pct);
      send_item(OP_WORD, 6'($urandom), 4'($urandom), $urandom,
                (k == 7) ? xpsr : $urandom, 1'b1);
    end
    handler = (code == RET_HANDLER);
  endtask

  task automatic random_sequence();
    int unsigned r;
    logic [5:0]  exc;
    logic [3:0]  code;
    r = $urandom_range(99);
    do exc = 6'($urandom); while (exc inside {[6'd0:6'd1], [6'd4:6'd10], 6'd12, 6'd13});
    case ($urandom_range(2))
      0: code = RET_HANDLER;
      1: code = RET_THREAD_MSP;
      default: code = RET_THREAD_PSP;
    endcase
    if ((!handler && r < 75) || (handler && r < 40)) begin
      entry_sequence(exc, $urandom, $urandom, 10);
    end else if (handler && r < 85) begin
      return_sequence(code, $urandom, 10);
    end else if (r < 92) begin
      if (handler) begin
        do code = 4'($urandom);
        while (code inside {RET_HANDLER, RET_THREAD_MSP, RET_THREAD_PSP});
        send_item(OP_RETURN, 6'($urandom), code, $urandom, $urandom, 1'b1);
      end else if (r < 85) begin
        send_item(OP_RETURN, 6'($urandom), 4'($urandom), $urandom, $urandom, 1'b1);
      end else begin
        do exc = 6'($urandom_range(13)); while (exc inside {6'd2, 6'd3, 6'd11});
        send_item(OP_ENTRY, exc, 4'($urandom), $urandom, $urandom, 1'b1);
      end
    end else begin
      send_item(r[0] ? OP_WORD : OP_UNUSED, 6'($urandom), 4'($urandom), $urandom,
                $urandom, 1'b0);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    items_sent = 0;
    tx_idle_pct = 17;
    rx_idle_pct = 47;
    handler = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    write_cfg(CFG_VECTOR_BASE, 32'hFFFF_FFF0);
    write_cfg(CFG_THREAD_UNPRIV, 32'd1);

    // return from thread mode, reserved exceptions, ignored items
    send_item(OP_RETURN, 6'd2, RET_HANDLER, 32'd0, 32'd0, 1'b1);
    send_item(OP_ENTRY, 6'd0, 4'd0, 32'hFFFF_FFFF, 32'd0, 1'b1);
    send_item(OP_ENTRY, 6'd1, 4'd0, 32'd0, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_WORD, 6'd63, 4'd15, 32'd0, 32'hFFFF_FFFF, 1'b0);
    send_item(OP_UNUSED, 6'd2, 4'd1, 32'd0, 32'd0, 1'b0);
    // padded frame below address zero, vector fetch wraps
    entry_sequence(6'd63, 32'h0000_0004, 32'hFFFF_FDFF, 30);
    send_item(OP_RETURN, 6'd2, 4'd0, 32'd0, 32'd0, 1'b1);
    send_item(OP_RETURN, 6'd2, 4'd15, 32'd0, 32'd0, 1'b1);
    return_sequence(RET_THREAD_PSP, 32'hF700_023F, 30);

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0: begin
          tx_idle_pct = 17;
          rx_idle_pct = 47;
          write_cfg(CFG_VECTOR_BASE, 32'd0);
          write_cfg(CFG_THREAD_UNPRIV, 32'd0);
        end
        1: begin
          tx_idle_pct = 47;
          rx_idle_pct = 17;
          write_cfg(CFG_VECTOR_BASE, 32'hFFFF_FFFF);
          write_cfg(CFG_THREAD_UNPRIV, 32'd1);
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          write_cfg(CFG_VECTOR_BASE, $urandom);
          write_cfg(CFG_THREAD_UNPRIV, $urandom_range(1));
        end
      endcase
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) random_sequence();
    end

    drain();
    if (fail_count == 0 && results_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
